### rtl/core/dead_reckoning_pose_integrator_top_assert.svh
// Assertion macros for the pose integrator top level.
`ifndef DEAD_RECKONING_POSE_INTEGRATOR_TOP_ASSERT_SVH
`define DEAD_RECKONING_POSE_INTEGRATOR_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DR_ASSERT_IMP(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define DR_ASSERT_NXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define DR_ASSERT_IMP(lbl, a, c, msg)
`define DR_ASSERT_NXT(lbl, a, c, msg)
`endif
`endif

### rtl/core/drpi_pkg.sv
// Package for the pose integrator: widths, constants, CORDIC table.
`default_nettype none
package drpi_pkg;
    localparam int SINCOS_STEPS_DEF = 16;
    localparam int CORDIC_LEN = 24;
    localparam logic [15:0] TIMEOUT_RESET = 16'd6554;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [16:0] SINCE_MAX = 17'h1FFFF;
    localparam logic OP_CMD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [31:0] pose_x;
        logic [31:0] pose_y;
        logic [15:0] heading;
        logic        timed_out;
    } pose_t;

    typedef struct packed {
        logic        opcode;
        logic [15:0] linear_speed_cmd;
        logic [23:0] turn_rate_cmd;
        logic [15:0] time_step;
    } cmd_t;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051D; 5'd2: r = 32'h09FB385B;
            5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
            5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
            5'd9: r = 32'h00145F2E; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F; 5'd19: r = 32'h00000517; 5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145; 5'd22: r = 32'h000000A2; 5'd23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

### rtl/core/drpi_if.sv
// Valid/ready stream interfaces for command and pose beats.
`default_nettype none
interface drpi_cmd_if;
    import drpi_pkg::*;
    logic valid;
    logic ready;
    cmd_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface drpi_pose_if;
    import drpi_pkg::*;
    logic  valid;
    logic  ready;
    pose_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/dead_reckoning_pose_integrator_top.sv
// Pose integrator top: bit-serial multiplies, iterative CORDIC, saturating accumulate.
// A command beat goes from S_IDLE straight to S_OUT, where its pose loads once the output is free.
// A tick goes through S_MULA, S_PREP, S_CORD, S_MULX, S_ACC and S_OUT, its products formed by
// the bit-serial shift-add multipliers and its sine and cosine by the one-step-per-cycle CORDIC.
// One beat is in work at a time; the next is taken the cycle after the pose is loaded.
// rst_n clears pose, speeds, elapsed time and sets the timeout to 6554.
`default_nettype none
module dead_reckoning_pose_integrator_top #(
    parameter int SINCOS_STEPS = drpi_pkg::SINCOS_STEPS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    drpi_cmd_if.sink         cmd,
    drpi_pose_if.source      pose,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);
    import drpi_pkg::*;

    localparam int NSTEP = (SINCOS_STEPS > CORDIC_LEN) ? CORDIC_LEN : SINCOS_STEPS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULA = 3'd1; // heading and distance products, serial over dt
    localparam logic [2:0] S_PREP = 3'd2;
    localparam logic [2:0] S_CORD = 3'd3;
    localparam logic [2:0] S_MULX = 3'd4; // dist*cos and dist*sin, serial over cos/sin
    localparam logic [2:0] S_ACC  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    logic [15:0] timeout_reg;
    logic signed [31:0] px_reg, py_reg;
    logic [31:0] hd_reg;
    logic signed [15:0] lin_reg;
    logic signed [23:0] rate_reg;
    logic [16:0] since_reg;
    logic        timed_reg;
    logic [5:0]  cnt_reg;
    // serial multiplier of speed/rate by dt
    logic [15:0] dt_sh_reg;
    logic signed [39:0] hacc_reg, dacc_reg;
    logic signed [39:0] hadd_reg, dadd_reg;
    // CORDIC
    logic signed [33:0] cx_reg, cy_reg;
    logic signed [32:0] cz_reg;
    logic        flip_reg;
    // second multiply: dist (Q8.24, 33 bit) by cos/sin (34 bit)
    logic signed [33:0] mc_reg, ms_reg;
    logic signed [67:0] pxacc_reg, pyacc_reg, mdist_reg;
    logic        out_v_reg;
    pose_t       out_reg;

    assign cmd.ready = (state_reg == S_IDLE);
    assign pose.valid = out_v_reg;
    assign pose.data = out_reg;

    logic acc_in;
    assign acc_in = cmd.valid && cmd.ready;

    // in S_OUT, the output register loads when empty or emptied this cycle
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_v_reg || pose.ready);

    // saturating add of a rounded Q16.16 delta
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                   input logic signed [67:0] prod);
        logic signed [67:0] rr;
        logic signed [68:0] r;
        rr = (prod + (68'sd1 <<< 37)) >>> 38;
        r = {{37{p[31]}}, p} + {rr[67], rr};
        if (r > 69'sd2147483647) return 32'sh7FFFFFFF;
        if (r < -69'sd2147483648) return 32'sh80000000;
        return r[31:0];
    endfunction

    logic [16:0] since_sum;
    logic [17:0] since_raw;
    assign since_raw = {1'b0, since_reg} + {2'b0, cmd.data.time_step};
    assign since_sum = since_raw[17] ? SINCE_MAX : since_raw[16:0];
    logic [31:0] hd_new;
    assign hd_new = hd_reg + hacc_reg[31:0];
    logic [31:0] u_ang;
    assign u_ang = flip_reg ? hd_reg + 32'h80000000 : hd_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (acc_in) state_next = cmd.data.opcode == OP_TICK ? S_MULA : S_OUT;
            S_MULA: if (cnt_reg == 6'd15) state_next = S_PREP;
            S_PREP: state_next = S_CORD;
            S_CORD: if (cnt_reg == 6'(NSTEP - 1)) state_next = S_MULX;
            S_MULX: if (cnt_reg == 6'd33) state_next = S_ACC;
            S_ACC:  state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            timeout_reg <= TIMEOUT_RESET;
            px_reg <= '0; py_reg <= '0; hd_reg <= '0;
            lin_reg <= '0; rate_reg <= '0; since_reg <= '0;
            timed_reg <= 1'b0; cnt_reg <= '0; out_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we) timeout_reg <= cfg_wdata;
            if (out_load)
                out_v_reg <= 1'b1;
            else if (pose.ready)
                out_v_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (acc_in)
                    begin
                        timed_reg <= 1'b0;
                        if (cmd.data.opcode == OP_CMD)
                        begin
                            lin_reg <= cmd.data.linear_speed_cmd;
                            rate_reg <= cmd.data.turn_rate_cmd;
                            since_reg <= '0;
                        end
                        else
                        begin
                            since_reg <= since_sum;
                            dt_sh_reg <= cmd.data.time_step;
                            hacc_reg <= '0; dacc_reg <= '0;
                            if (since_sum > {1'b0, timeout_reg})
                            begin
                                lin_reg <= '0; rate_reg <= '0; timed_reg <= 1'b1;
                                hadd_reg <= '0; dadd_reg <= '0;
                            end
                            else
                            begin
                                hadd_reg <= 40'(rate_reg);
                                dadd_reg <= 40'(lin_reg);
                            end
                        end
                    end
                end
                S_MULA:
                begin
                    if (dt_sh_reg[0])
                    begin
                        hacc_reg <= hacc_reg + hadd_reg;
                        dacc_reg <= dacc_reg + dadd_reg;
                    end
                    hadd_reg <= hadd_reg <<< 1;
                    dadd_reg <= dadd_reg <<< 1;
                    dt_sh_reg <= dt_sh_reg >> 1;
                    cnt_reg <= (cnt_reg == 6'd15) ? 6'd0 : cnt_reg + 6'd1;
                end
                S_PREP:
                begin
                    hd_reg <= hd_new;
                    flip_reg <= hd_new[31] ^ hd_new[30];
                    mdist_reg <= 68'(dacc_reg);
                    cx_reg <= CORDIC_GAIN; cy_reg <= '0;
                end
                S_CORD:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        // first step: z taken from the folded heading
                        if (!u_ang[31])
                        begin
                            cx_reg <= cx_reg - cy_reg; cy_reg <= cy_reg + cx_reg;
                            cz_reg <= {u_ang[31], u_ang} - 33'(atan_turn(5'd0));
                        end
                        else
                        begin
                            cx_reg <= cx_reg + cy_reg; cy_reg <= cy_reg - cx_reg;
                            cz_reg <= {u_ang[31], u_ang} + 33'(atan_turn(5'd0));
                        end
                    end
                    else if (!cz_reg[32])
                    begin
                        cx_reg <= cx_reg - (cy_reg >>> cnt_reg[4:0]);
                        cy_reg <= cy_reg + (cx_reg >>> cnt_reg[4:0]);
                        cz_reg <= cz_reg - 33'(atan_turn(cnt_reg[4:0]));
                    end
                    else
                    begin
                        cx_reg <= cx_reg + (cy_reg >>> cnt_reg[4:0]);
                        cy_reg <= cy_reg - (cx_reg >>> cnt_reg[4:0]);
                        cz_reg <= cz_reg + 33'(atan_turn(cnt_reg[4:0]));
                    end
                    if (cnt_reg == 6'(NSTEP - 1))
                    begin
                        cnt_reg <= '0;
                        pxacc_reg <= '0; pyacc_reg <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 6'd1;
                end
                S_MULX:
                begin
                    if (cnt_reg == 6'd0)
                    begin
                        // load multipliers: x uses cos, y uses -sin, flip folds in
                        mc_reg <= flip_reg ? -cx_reg : cx_reg;
                        ms_reg <= flip_reg ? cy_reg : -cy_reg;
                        cnt_reg <= 6'd1;
                    end
                    else
                    begin
                        // two's-complement shift-add, top bit weighted negative
                        if (mc_reg[0])
                            pxacc_reg <= (cnt_reg == 6'd33) ? pxacc_reg - mdist_reg
                                                            : pxacc_reg + mdist_reg;
                        if (ms_reg[0])
                            pyacc_reg <= (cnt_reg == 6'd33) ? pyacc_reg - mdist_reg
                                                            : pyacc_reg + mdist_reg;
                        mc_reg <= mc_reg >>> 1;
                        ms_reg <= ms_reg >>> 1;
                        mdist_reg <= mdist_reg <<< 1;
                        cnt_reg <= (cnt_reg == 6'd33) ? 6'd0 : cnt_reg + 6'd1;
                    end
                end
                S_ACC:
                begin
                    px_reg <= sat_add(px_reg, pxacc_reg);
                    py_reg <= sat_add(py_reg, pyacc_reg);
                end
                S_OUT:
                begin
                    // holds here while the previous pose still waits
                    if (out_load)
                    begin
                        out_reg.pose_x <= px_reg;
                        out_reg.pose_y <= py_reg;
                        out_reg.heading <= hd_reg[31:16];
                        out_reg.timed_out <= timed_reg;
                    end
                end
                default: ;
            endcase
        end
    end

`include "dead_reckoning_pose_integrator_top_assert.svh"
    `DR_ASSERT_IMP(a_no_take_busy, state_reg != S_IDLE, !cmd.ready, "beat taken while busy")
    `DR_ASSERT_NXT(a_out_follows, state_reg == S_OUT, out_v_reg, "pose not presented")
    `DR_ASSERT_IMP(a_since_cap, 1'b1, since_reg <= SINCE_MAX, "elapsed time overflow")
endmodule
`default_nettype wire

### sim/tb_dead_reckoning_pose_integrator_top.sv
// Testbench for the dead-reckoning pose integrator: predicted poses checked beat by beat.
`default_nettype none
module tb_dead_reckoning_pose_integrator_top;
    import drpi_pkg::*;

    localparam int STEPS = SINCOS_STEPS_DEF;
    localparam int TICK_LATENCY = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    drpi_cmd_if cmd_bus ();
    drpi_pose_if pose_bus ();

    dead_reckoning_pose_integrator_top #(.SINCOS_STEPS(STEPS)) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_bus.sink),
        .pose      (pose_bus.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // Predictor state, mirrors the block's own registers.
    logic [15:0]        timeout_q16;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        head_ang;
    logic signed [15:0] lin_spd;
    logic signed [23:0] turn_spd;
    logic [16:0]        elapsed;

    pose_t pending_poses[$];
    int    error_count = 0;
    int    beats_sent = 0;
    int    beats_checked = 0;
    int    timeouts_seen = 0;
    bit    sink_stall_en = 1'b1;

    // Initial drive levels; valid stays low until the first beat.
    initial
    begin
        cmd_bus.valid = 1'b0;
        cmd_bus.data = '0;
        pose_bus.ready = 1'b0;
    end

    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] t [24];
        t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
              32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
              32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
              32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
              32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};
        return t[i];
    endfunction

    // Rotation-mode CORDIC on a binary angle; >>> on signed is a floor shift.
    task automatic rotate_unit(input logic [31:0] ang, output longint c, output longint s);
        bit flip;
        logic [31:0] u;
        longint z, xv, yv, xs, ys;
        int n;
        flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
        u = flip ? ang + 32'h80000000 : ang;
        z = longint'($signed(u));
        xv = 652032874;
        yv = 0;
        n = (STEPS > 24) ? 24 : STEPS;
        for (int i = 0; i < n; i++)
        begin
            xs = xv >>> i;
            ys = yv >>> i;
            if (z >= 0)
            begin
                xv = xv - ys; yv = yv + xs; z = z - longint'(atan_step(i));
            end
            else
            begin
                xv = xv + ys; yv = yv - xs; z = z + longint'(atan_step(i));
            end
        end
        c = flip ? -xv : xv;
        s = flip ? -yv : yv;
    endtask

    function automatic logic signed [31:0] add_clamped(input logic signed [31:0] p,
                                                       input longint d);
        longint r;
        r = longint'(p) + d;
        if (r > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (r < -64'sd2147483648)
            return 32'sh80000000;
        return r[31:0];
    endfunction

    // Q.54 product to Q16.16, round half up. Products fit in 64 bits.
    function automatic longint round_q16(input longint prod);
        return (prod + (64'sd1 <<< 37)) >>> 38;
    endfunction

    task automatic advance_pose(input cmd_t beat, output pose_t res);
        longint dt, travel, c, s, dturn;
        res.timed_out = 1'b0;
        if (beat.opcode == OP_CMD)
        begin
            lin_spd = beat.linear_speed_cmd;
            turn_spd = beat.turn_rate_cmd;
            elapsed = '0;
        end
        else
        begin
            dt = longint'(beat.time_step);
            if (longint'(elapsed) + dt > 131071)
                elapsed = SINCE_MAX;
            else
                elapsed = elapsed + beat.time_step;
            if (elapsed > {1'b0, timeout_q16})
            begin
                lin_spd = '0;
                turn_spd = '0;
                res.timed_out = 1'b1;
            end
            dturn = longint'(turn_spd) * dt;
            head_ang = head_ang + dturn[31:0];
            travel = longint'(lin_spd) * dt;
            rotate_unit(head_ang, c, s);
            pos_x = add_clamped(pos_x, round_q16(travel * c));
            pos_y = add_clamped(pos_y, round_q16(-(travel * s)));
        end
        res.pose_x = pos_x;
        res.pose_y = pos_y;
        res.heading = head_ang[31:16];
    endtask

    // Send one beat with a random lead-in gap; predict at acceptance.
    // valid stays high after acceptance until the next gap or drain drops it.
    task automatic send_beat(input cmd_t beat, input bit no_gap = 1'b0);
        pose_t exp_pose;
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16));
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_bus.data <= beat;
        cmd_bus.valid <= 1'b1;
        do @(posedge clk); while (!cmd_bus.ready);
        advance_pose(beat, exp_pose);
        pending_poses.push_back(exp_pose);
        beats_sent++;
        if (beat.opcode == OP_TICK && exp_pose.timed_out)
            timeouts_seen++;
        @(negedge clk);
    endtask

    function automatic cmd_t make_cmd(input logic [15:0] lin, input logic [23:0] turn);
        cmd_t b;
        b.opcode = OP_CMD;
        b.linear_speed_cmd = lin;
        b.turn_rate_cmd = turn;
        b.time_step = 16'($urandom);
        return b;
    endfunction

    function automatic cmd_t make_tick(input logic [15:0] dt);
        cmd_t b;
        b.opcode = OP_TICK;
        b.linear_speed_cmd = 16'($urandom);
        b.turn_rate_cmd = 24'($urandom);
        b.time_step = dt;
        return b;
    endfunction

    // Waits for every pose; a tick's pose means the block is idle again.
    task automatic drain_poses();
        cmd_bus.valid <= 1'b0;
        while (pending_poses.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [15:0] value);
        drain_poses();
        cfg_wdata <= value;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        timeout_q16 = value;
    endtask

    // Receiver: random stalls per beat when enabled, compare each pose with the oldest prediction.
    initial
    begin
        pose_t got, want;
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = sink_stall_en ? $urandom_range(0, 16) : 0;
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                pose_bus.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            pose_bus.ready <= 1'b1;
            do @(posedge clk); while (!pose_bus.valid);
            got = pose_bus.data;
            if (pending_poses.size() == 0)
            begin
                $error("pose beat with nothing expected");
                error_count++;
            end
            else
            begin
                want = pending_poses.pop_front();
                beats_checked++;
                if (got.pose_x !== want.pose_x)
                begin
                    $error("pose_x expected %0d got %0d",
                           $signed(want.pose_x), $signed(got.pose_x));
                    error_count++;
                end
                if (got.pose_y !== want.pose_y)
                begin
                    $error("pose_y expected %0d got %0d",
                           $signed(want.pose_y), $signed(got.pose_y));
                    error_count++;
                end
                if (got.heading !== want.heading)
                begin
                    $error("heading expected %0d got %0d",
                           $signed(want.heading), $signed(got.heading));
                    error_count++;
                end
                if (got.timed_out !== want.timed_out)
                begin
                    $error("timed_out expected %0b got %0b", want.timed_out, got.timed_out);
                    error_count++;
                end
            end
        end
    end

    // Extremes of each field, command-only pose report, timeout edges.
    task automatic test_directed();
        send_beat(make_cmd(16'h0000, 24'h000000));
        send_beat(make_tick(16'h0000));
        send_beat(make_cmd(16'h7FFF, 24'h7FFFFF));
        send_beat(make_tick(16'd6554));     // exactly at the timeout: keeps speeds
        send_beat(make_tick(16'd1));        // one past: speeds zeroed
        send_beat(make_tick(16'd100));      // already zero, still flags timeout
        send_beat(make_cmd(16'h8000, 24'h800000));
        send_beat(make_tick(16'd3000));
        send_beat(make_tick(16'd3000));
        send_beat(make_cmd(16'hFFFF, 24'hFFFFFF));
        send_beat(make_tick(16'hFFFF));     // elapsed time past the limit
        send_beat(make_tick(16'hFFFF));
        send_beat(make_tick(16'hFFFF));     // elapsed time saturates
        send_beat(make_cmd(16'h7FFF, 24'h400000));
        send_beat(make_tick(16'h0001));
        send_beat(make_cmd(16'h5555, 24'hAAAAAA));
        send_beat(make_tick(16'h5555));
        send_beat(make_cmd(16'hAAAA, 24'h555555));
        send_beat(make_tick(16'hAAAA));
    endtask

    // Full-speed runs with both extreme timeouts.
    task automatic test_timeout_extremes();
        write_timeout(16'hFFFF);
        send_beat(make_cmd(16'h7FFF, 24'h000000));
        repeat (40) send_beat(make_tick(16'hFFFF), 1'b1);
        send_beat(make_cmd(16'h8000, 24'h000000));
        repeat (40) send_beat(make_tick(16'hFFFF));
        send_beat(make_cmd(16'h7FFF, 24'h400000));
        repeat (40) send_beat(make_tick(16'h8000));
        write_timeout(16'h0000);
        send_beat(make_cmd(16'h1234, 24'h123456));
        send_beat(make_tick(16'h0000));     // zero elapsed is not past zero
        send_beat(make_tick(16'h0001));
    endtask

    // Well-formed command/tick sessions with random content, some noise.
    task automatic test_random_sessions(input int count, input logic [15:0] tmo);
        int sent;
        int ticks;
        write_timeout(tmo);
        sent = 0;
        while (sent < count)
        begin
            send_beat(make_cmd(16'($urandom), 24'($urandom)));
            sent++;
            ticks = $urandom_range(1, 8);
            repeat (ticks)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_beat(make_tick(16'($urandom)));
                else
                    send_beat(make_tick(16'($urandom_range(0, 2000))));
                sent++;
            end
        end
    endtask

    initial
    begin
        timeout_q16 = TIMEOUT_RESET;
        pos_x = '0;
        pos_y = '0;
        head_ang = '0;
        lin_spd = '0;
        turn_spd = '0;
        elapsed = '0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        // Hold off until every pose is back, then resume.
        drain_poses();
        test_timeout_extremes();
        test_random_sessions(500, TIMEOUT_RESET);
        sink_stall_en = 1'b0;
        test_random_sessions(300, 16'd1500);
        sink_stall_en = 1'b1;
        test_random_sessions(700, 16'($urandom));

        drain_poses();
        repeat (TICK_LATENCY) @(negedge clk);
        $display("covered %0d beats, %0d poses checked, %0d timeouts, timeouts 0..65535",
                 beats_sent, beats_checked, timeouts_seen);
        if (error_count == 0 && pending_poses.size() == 0)
            $display("dead_reckoning_pose_integrator_top: match");
        else
            $display("dead_reckoning_pose_integrator_top: mismatch");
        $finish;
    end

    // Watchdog: ends the run as a mismatch if the ~1700 beats have not finished first.
    initial
    begin
        #20000000;
        $display("dead_reckoning_pose_integrator_top: mismatch");
        $finish;
    end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/drpi_pkg.sv
rtl/core/drpi_if.sv
rtl/core/dead_reckoning_pose_integrator_top.sv
sim/tb_dead_reckoning_pose_integrator_top.sv
